FILE: src/lscs_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the 3x3 Cramer's rule solver.
// No dependencies.
package lscs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] a00;
    logic signed [DATA_WIDTH-1:0] a01;
    logic signed [DATA_WIDTH-1:0] a02;
    logic signed [DATA_WIDTH-1:0] a10;
    logic signed [DATA_WIDTH-1:0] a11;
    logic signed [DATA_WIDTH-1:0] a12;
    logic signed [DATA_WIDTH-1:0] a20;
    logic signed [DATA_WIDTH-1:0] a21;
    logic signed [DATA_WIDTH-1:0] a22;
    logic signed [DATA_WIDTH-1:0] rhs0;
    logic signed [DATA_WIDTH-1:0] rhs1;
    logic signed [DATA_WIDTH-1:0] rhs2;
  } lscs_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sol_x;
    logic signed [DATA_WIDTH-1:0] sol_y;
    logic signed [DATA_WIDTH-1:0] sol_z;
    logic                         singular;
  } lscs_out_t;

endpackage

FILE: src/linear_system3_cramer_solver.sv
`timescale 1ns / 1ps
// 3x3 linear solver by Cramer's rule: products, cofactors, determinants,
// then one restoring quotient bit per stage. Depends on lscs_pkg.
// Throughput: one item per cycle unless out_stall holds the pipeline.
// Reset clears only the stage valid bits; payload registers keep stale data.
module linear_system3_cramer_solver #(
  parameter int FRAC_BITS = lscs_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lscs_pkg::lscs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lscs_pkg::lscs_out_t out_data
);

  localparam int W   = lscs_pkg::DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int TW  = 3 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int XW  = DW + W + FRAC_BITS;
  localparam int SD  = 5;
  localparam int NS  = SD + W + 2;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   adv;

  assign adv[NS] = !out_stall;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !v_r[i] || adv[i+1];
  end

  assign v_nxt     = {v_r[NS-2:0], in_valid};
  assign in_stall  = !adv[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_nxt[i];
        end
      end
    end
  end

  // stage 0: 2x2 products of rows 1 and 2 for all four determinants
  logic signed [W-1:0]  row0_in [4][3];
  logic signed [W-1:0]  r1 [4][3];
  logic signed [W-1:0]  r2 [4][3];
  logic signed [PW-1:0] prod_nxt [4][6];
  logic signed [PW-1:0] prod_r [4][6];
  logic signed [W-1:0]  row0_0_r [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      row0_in[d][0] = (d == 1) ? in_data.rhs0 : in_data.a00;
      row0_in[d][1] = (d == 2) ? in_data.rhs0 : in_data.a01;
      row0_in[d][2] = (d == 3) ? in_data.rhs0 : in_data.a02;
      r1[d][0] = (d == 1) ? in_data.rhs1 : in_data.a10;
      r1[d][1] = (d == 2) ? in_data.rhs1 : in_data.a11;
      r1[d][2] = (d == 3) ? in_data.rhs1 : in_data.a12;
      r2[d][0] = (d == 1) ? in_data.rhs2 : in_data.a20;
      r2[d][1] = (d == 2) ? in_data.rhs2 : in_data.a21;
      r2[d][2] = (d == 3) ? in_data.rhs2 : in_data.a22;
      prod_nxt[d][0] = r1[d][1] * r2[d][2];
      prod_nxt[d][1] = r1[d][2] * r2[d][1];
      prod_nxt[d][2] = r1[d][0] * r2[d][2];
      prod_nxt[d][3] = r1[d][2] * r2[d][0];
      prod_nxt[d][4] = r1[d][0] * r2[d][1];
      prod_nxt[d][5] = r1[d][1] * r2[d][0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      prod_r   <= prod_nxt;
      row0_0_r <= row0_in;
    end
  end

  // stage 1: signed cofactors, middle one negated
  logic signed [CW-1:0] cof_nxt [4][3];
  logic signed [CW-1:0] cof_r [4][3];
  logic signed [W-1:0]  row0_1_r [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      cof_nxt[d][0] = CW'(prod_r[d][0]) - CW'(prod_r[d][1]);
      cof_nxt[d][1] = CW'(prod_r[d][3]) - CW'(prod_r[d][2]);
      cof_nxt[d][2] = CW'(prod_r[d][4]) - CW'(prod_r[d][5]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      cof_r    <= cof_nxt;
      row0_1_r <= row0_0_r;
    end
  end

  // stage 2: first-row element times cofactor, split in low and high halves
  logic signed [W:0]    cof_lo [4][3];
  logic signed [W:0]    cof_hi [4][3];
  logic signed [CW-1:0] pl_nxt [4][3];
  logic signed [CW-1:0] ph_nxt [4][3];
  logic signed [CW-1:0] pl_r [4][3];
  logic signed [CW-1:0] ph_r [4][3];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      for (int c = 0; c < 3; c++) begin
        cof_lo[d][c] = $signed({1'b0, cof_r[d][c][W-1:0]});
        cof_hi[d][c] = $signed(cof_r[d][c][CW-1:W]);
        pl_nxt[d][c] = row0_1_r[d][c] * cof_lo[d][c];
        ph_nxt[d][c] = row0_1_r[d][c] * cof_hi[d][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
  end

  // stage 3: recombine halves and sum the expansion
  logic signed [TW-1:0] term [4][3];
  logic signed [DW-1:0] det_nxt [4];
  logic signed [DW-1:0] det_r [4];

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      for (int c = 0; c < 3; c++) begin
        term[d][c] = (TW'(ph_r[d][c]) <<< W) + TW'(pl_r[d][c]);
      end
      det_nxt[d] = DW'(term[d][0]) + DW'(term[d][1]) + DW'(term[d][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      det_r <= det_nxt;
    end
  end

  // stage 4: magnitudes and result signs
  logic [DW-1:0] nmag_nxt [3];
  logic [DW-1:0] nmag_r [3];
  logic [DW-1:0] dmag_nxt;
  logic [DW-1:0] dmag_r;
  logic [2:0]    neg_nxt;
  logic [2:0]    neg4_r;
  logic          sing4_r;

  always_comb begin
    dmag_nxt = det_r[0][DW-1] ? DW'(-det_r[0]) : DW'(det_r[0]);
    for (int u = 0; u < 3; u++) begin
      nmag_nxt[u] = det_r[u+1][DW-1] ? DW'(-det_r[u+1]) : DW'(det_r[u+1]);
      neg_nxt[u]  = det_r[u+1][DW-1] ^ det_r[0][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      nmag_r  <= nmag_nxt;
      dmag_r  <= dmag_nxt;
      neg4_r  <= neg_nxt;
      sing4_r <= (det_r[0] == '0);
    end
  end

  // divider chain: entry stage checks overflow, then one quotient bit a stage
  logic [XW-1:0] rem_nxt [W+1][3];
  logic [XW-1:0] rem_r [W+1][3];
  logic [W-1:0]  q_nxt [W+1][3];
  logic [W-1:0]  q_r [W+1][3];
  logic [DW-1:0] dm_r [W+1];
  logic [2:0]    sat_nxt [W+1];
  logic [2:0]    sat_r [W+1];
  logic [2:0]    neg_r [W+1];
  logic          sing_r [W+1];

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      rem_nxt[0][u] = XW'(nmag_r[u]) << FRAC_BITS;
      q_nxt[0][u]   = '0;
      sat_nxt[0][u] = rem_nxt[0][u] >= (XW'(dmag_r) << W);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[SD]) begin
      rem_r[0]  <= rem_nxt[0];
      q_r[0]    <= q_nxt[0];
      sat_r[0]  <= sat_nxt[0];
      dm_r[0]   <= dmag_r;
      neg_r[0]  <= neg4_r;
      sing_r[0] <= sing4_r;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    localparam int K = W - j;
    always_comb begin
      logic [XW-1:0] dk;
      logic          qb;
      dk = XW'(dm_r[j-1]) << K;
      for (int u = 0; u < 3; u++) begin
        qb = rem_r[j-1][u] >= dk;
        rem_nxt[j][u] = qb ? rem_r[j-1][u] - dk : rem_r[j-1][u];
        q_nxt[j][u]   = {q_r[j-1][u][W-2:0], qb};
      end
      sat_nxt[j] = sat_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv[SD+j]) begin
        rem_r[j]  <= rem_nxt[j];
        q_r[j]    <= q_nxt[j];
        sat_r[j]  <= sat_nxt[j];
        dm_r[j]   <= dm_r[j-1];
        neg_r[j]  <= neg_r[j-1];
        sing_r[j] <= sing_r[j-1];
      end
    end
  end

  // output stage: saturate, apply sign, clear on singular
  logic [W-1:0]       sol_nxt [3];
  lscs_pkg::lscs_out_t out_nxt;
  lscs_pkg::lscs_out_t out_r;

  always_comb begin
    for (int u = 0; u < 3; u++) begin
      if (sing_r[W]) begin
        sol_nxt[u] = '0;
      end else if (!neg_r[W][u]) begin
        if (sat_r[W][u] || q_r[W][u][W-1]) begin
          sol_nxt[u] = {1'b0, {(W-1){1'b1}}};
        end else begin
          sol_nxt[u] = q_r[W][u];
        end
      end else begin
        if (sat_r[W][u] || (q_r[W][u][W-1] && (|q_r[W][u][W-2:0]))) begin
          sol_nxt[u] = {1'b1, {(W-1){1'b0}}};
        end else begin
          sol_nxt[u] = W'(-q_r[W][u]);
        end
      end
    end
    out_nxt.sol_x    = $signed(sol_nxt[0]);
    out_nxt.sol_y    = $signed(sol_nxt[1]);
    out_nxt.sol_z    = $signed(sol_nxt[2]);
    out_nxt.singular = sing_r[W];
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
